[hdl/wsfd_pkg.sv]
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam int LENGTH_BITS = 64;
    localparam int LEN_W       = LENGTH_BITS;

    localparam logic [LEN_W-1:0] LEN_MAX     = '1;
    localparam logic [LEN_W-1:0] LEN_SAT_LIM = LEN_MAX >> 8;

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_MASK = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;
    localparam logic [2:0] PH_TAIL = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_NOT_FINAL = 2'd2;
    localparam logic [1:0] ST_CLOSE     = 2'd3;

    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [6:0] LEN_CODE16 = 7'd126;
    localparam logic [6:0] LEN_CODE64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic       frame_done;
        logic       byte_valid;
        logic [7:0] payload_byte;
    } t_result;

endpackage

[hdl/wsfd_in_stage.sv]
// ----------------------------------------------------------------------------
// wsfd_in_stage
// Input register: captures one received byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module wsfd_in_stage
    import wsfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_s_tready = !r_valid || i_advance;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hdl/wsfd_parser.sv]
// ----------------------------------------------------------------------------
// wsfd_parser
// Header parse, length tracking and payload unmasking, one byte per step.
// ----------------------------------------------------------------------------
module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output logic    o_has_result,
    output t_result o_result
);

    logic [2:0]       r_phase, n_phase;
    logic             r_fin, n_fin;
    logic             r_close, n_close;
    logic             r_mask_on, n_mask_on;
    logic [3:0]       r_hleft, n_hleft;
    logic [LEN_W-1:0] r_length, n_length;
    logic [LEN_W-1:0] r_count, n_count;
    logic [31:0]      r_key, n_key;

    logic [7:0]       b;
    logic [7:0]       key_byte;
    logic [1:0]       status;
    logic             first;
    logic             valid;

    assign b     = i_item.rx_byte;
    assign first = (r_phase == PH_HDR0);

    always_comb begin
        case (r_count[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_fin     = r_fin;
        n_close   = r_close;
        n_mask_on = r_mask_on;
        n_hleft   = r_hleft;
        n_length  = r_length;
        n_count   = r_count;
        n_key     = r_key;
        valid     = 1'b0;
        status    = ST_OK;
        unique case (r_phase)
            PH_HDR0: begin
                n_fin   = b[7];
                n_close = (b[3:0] == OPC_CLOSE);
                n_phase = PH_HDR1;
            end
            PH_HDR1: begin
                n_mask_on = b[7];
                n_count   = '0;
                n_key     = '0;
                if (b[6:0] == LEN_CODE16) begin
                    n_hleft  = EXT16_BYTES;
                    n_length = '0;
                    n_phase  = PH_EXT;
                end else if (b[6:0] == LEN_CODE64) begin
                    n_hleft  = EXT64_BYTES;
                    n_length = '0;
                    n_phase  = PH_EXT;
                end else begin
                    n_length = {{(LEN_W-7){1'b0}}, b[6:0]};
                    if (b[7]) begin
                        n_hleft = KEY_BYTES;
                        n_phase = PH_MASK;
                    end else begin
                        n_phase = (b[6:0] != 7'd0) ? PH_PAY : PH_TAIL;
                    end
                end
            end
            PH_EXT: begin
                if (r_length > LEN_SAT_LIM) begin
                    n_length = LEN_MAX;
                end else begin
                    n_length = {r_length[LEN_W-9:0], b};
                end
                n_hleft = r_hleft - 4'd1;
                if (n_hleft == 4'd0) begin
                    if (r_mask_on) begin
                        n_hleft = KEY_BYTES;
                        n_phase = PH_MASK;
                    end else begin
                        n_phase = (n_length != '0) ? PH_PAY : PH_TAIL;
                    end
                end
            end
            PH_MASK: begin
                n_key   = {r_key[23:0], b};
                n_hleft = r_hleft - 4'd1;
                if (n_hleft == 4'd0) begin
                    n_phase = (r_length != '0) ? PH_PAY : PH_TAIL;
                end
            end
            PH_PAY: begin
                valid   = r_fin && !r_close;
                n_count = r_count + 1'b1;
                if (n_count >= r_length) begin
                    n_phase = PH_TAIL;
                end
            end
            default: begin
            end
        endcase

        if (first) begin
            status = ST_SHORT;
        end else if (!n_fin) begin
            status = ST_NOT_FINAL;
        end else if (n_phase != PH_TAIL) begin
            status = ST_SHORT;
        end else if (n_close) begin
            status = ST_CLOSE;
        end else begin
            status = ST_OK;
        end

        if (i_item.buffer_end) begin
            n_phase   = PH_HDR0;
            n_fin     = 1'b0;
            n_close   = 1'b0;
            n_mask_on = 1'b0;
            n_hleft   = 4'd0;
        end
    end

    assign o_has_result          = valid || i_item.buffer_end;
    assign o_result.payload_byte = valid ? (b ^ key_byte) : 8'd0;
    assign o_result.byte_valid   = valid;
    assign o_result.frame_done   = i_item.buffer_end;
    assign o_result.status       = i_item.buffer_end ? status : ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_fin     <= 1'b0;
            r_close   <= 1'b0;
            r_mask_on <= 1'b0;
            r_hleft   <= 4'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_fin     <= n_fin;
            r_close   <= n_close;
            r_mask_on <= n_mask_on;
            r_hleft   <= n_hleft;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_length <= n_length;
            r_count  <= n_count;
            r_key    <= n_key;
        end
    end

`ifndef ASSERT_OFF
    a_end_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.buffer_end) |=> (r_phase == PH_HDR0))
        else $error("phase not back to first header byte after buffer end");

    a_hdr0_to_hdr1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_phase == PH_HDR0) && !i_item.buffer_end) |=> (r_phase == PH_HDR1))
        else $error("first header byte did not advance to second");

    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_count < r_length))
        else $error("payload count reached length while still in payload");

    a_hleft_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_EXT) || (r_phase == PH_MASK)) |-> (r_hleft != 4'd0))
        else $error("header byte counter empty in extended length or key phase");
`endif

endmodule

[hdl/wsfd_out_stage.sv]
// ----------------------------------------------------------------------------
// wsfd_out_stage
// Result register toward the downstream stream.
// ----------------------------------------------------------------------------
module wsfd_out_stage
    import wsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_ready,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast,
    output logic [2:0] o_m_tuser
);

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_result.payload_byte;
    assign o_m_tlast  = r_result.frame_done;
    assign o_m_tuser  = {r_result.status, r_result.byte_valid};

endmodule

[hdl/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// WebSocket receive-side frame decoder: header parse and payload unmasking.
// ----------------------------------------------------------------------------
// Takes one buffer byte per clock cycle (tlast on the last byte) and returns
// the unmasked payload bytes, with a status item on the last buffer byte.
// Throughput is one byte per cycle, sustained while downstream accepts; a
// stalled result register holds the input. The parse and unmask of a byte is
// combinational between the input register and the result register, so the
// result for a byte is loaded into the result register when the parser steps
// on it. Bytes that give no result (header, trailing bytes, suppressed
// payload) produce no output item. Downstream should discard a frame's bytes
// unless the status is ok.
module websocket_frame_deframer
    import wsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  logic       i_s_tlast,   // buffer_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] payload_byte
    output logic       o_m_tlast,   // frame_done
    output logic [2:0] o_m_tuser    // [0] byte_valid, [2:1] status
);

    t_item   s_item;
    t_item   in_item;
    logic    in_valid;
    logic    out_ready;
    logic    step;
    logic    has_result;
    t_result result;

    assign s_item.rx_byte    = i_s_tdata;
    assign s_item.buffer_end = i_s_tlast;
    assign step              = in_valid && out_ready;

    wsfd_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_item     (s_item),
        .i_advance  (out_ready),
        .o_valid    (in_valid),
        .o_item     (in_item)
    );

    wsfd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_item       (in_item),
        .o_has_result (has_result),
        .o_result     (result)
    );

    wsfd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step && has_result),
        .i_result   (result),
        .o_ready    (out_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
